FILE: rtl/tfd_pkg.sv
// shared types, register codes and table selection functions for the texel format decoder
package tfd_pkg;

	localparam int unsigned TexelW  = 16;
	localparam int unsigned ChanW   = 8;
	localparam int unsigned ChromaW = 9;
	localparam int unsigned SumW    = 11;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 64;
	localparam int unsigned LumaRegW  = 64;
	localparam int unsigned TripleW   = 3 * ChromaW;
	localparam int unsigned ChromaRegW = 2 * TripleW;

	typedef enum logic [1:0] {
		FMT_ARGB4444 = 2'd0,
		FMT_ARGB1555 = 2'd1,
		FMT_YIQ422   = 2'd2,
		FMT_BAD      = 2'd3
	} fmt_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TEXEL_FORMAT = 3'd0,
		REG_LUMA_LOW     = 3'd1,
		REG_LUMA_HIGH    = 3'd2,
		REG_I_LOW        = 3'd3,
		REG_I_HIGH       = 3'd4,
		REG_Q_LOW        = 3'd5,
		REG_Q_HIGH       = 3'd6
	} reg_idx_t;

	typedef struct packed {
		fmt_t                  fmt;
		logic [LumaRegW-1:0]   luma_lo;
		logic [LumaRegW-1:0]   luma_hi;
		logic [ChromaRegW-1:0] i_lo;
		logic [ChromaRegW-1:0] i_hi;
		logic [ChromaRegW-1:0] q_lo;
		logic [ChromaRegW-1:0] q_hi;
	} cfg_t;

	// chroma triple: r in the low bits, then g, then b
	typedef struct packed {
		logic signed [ChromaW-1:0] b;
		logic signed [ChromaW-1:0] g;
		logic signed [ChromaW-1:0] r;
	} triple_t;

	typedef struct packed {
		fmt_t             fmt;
		logic [ChanW-1:0] dr;
		logic [ChanW-1:0] dg;
		logic [ChanW-1:0] db;
		logic [ChanW-1:0] da;
		logic [ChanW-1:0] luma;
		triple_t          iv;
		triple_t          qv;
	} look_t;

	typedef struct packed {
		fmt_t                   fmt;
		logic [ChanW-1:0]       dr;
		logic [ChanW-1:0]       dg;
		logic [ChanW-1:0]       db;
		logic [ChanW-1:0]       da;
		logic signed [SumW-1:0] sr;
		logic signed [SumW-1:0] sg;
		logic signed [SumW-1:0] sb;
	} sum_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] alpha;
		logic             format_bad;
	} pix_t;

	function automatic logic [ChanW-1:0] luma_sel(
		input logic [LumaRegW-1:0] lo,
		input logic [LumaRegW-1:0] hi,
		input logic [3:0]          idx
	);
		logic [LumaRegW-1:0] word;
		word = idx[3] ? hi : lo;
		return word[{idx[2:0], 3'b000} +: ChanW];
	endfunction

	function automatic triple_t chroma_sel(
		input logic [ChromaRegW-1:0] lo,
		input logic [ChromaRegW-1:0] hi,
		input logic [1:0]            idx
	);
		logic [ChromaRegW-1:0] word;
		word = idx[1] ? hi : lo;
		return idx[0] ? word[ChromaRegW-1:TripleW] : word[TripleW-1:0];
	endfunction

	function automatic logic [ChanW-1:0] clamp8(input logic signed [SumW-1:0] v);
		logic [ChanW-1:0] res;
		if (v[SumW-1])
			res = '0;
		else if (v[SumW-2:ChanW] != '0)
			res = '1;
		else
			res = v[ChanW-1:0];
		return res;
	endfunction

endpackage

FILE: rtl/tfd_if.sv
// valid/ready channel interfaces for texel words, pixel words and register writes
interface tfd_texel_if;
	import tfd_pkg::*;
	logic              valid;
	logic              ready;
	logic [TexelW-1:0] texel_word;
	modport source (output valid, output texel_word, input ready);
	modport sink (input valid, input texel_word, output ready);
endinterface

interface tfd_pixel_if;
	import tfd_pkg::*;
	logic             valid;
	logic             ready;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;
	logic [ChanW-1:0] alpha;
	logic             format_bad;
	modport source (output valid, output red, output green, output blue, output alpha,
		output format_bad, input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		input format_bad, output ready);
endinterface

interface tfd_cfg_if;
	import tfd_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDatW-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/texel_format_decoder_core.sv
// texel format decoder top level: config registers and three-stage decode pipeline
//
//   channel  modport  word                                          handshake
//   texel    sink     texel_word[15:0]                              valid/ready
//   pixel    source   red, green, blue, alpha[7:0], format_bad      valid/ready
//   cfg      sink     index[2:0], data[63:0]                        valid/ready, ready tied high
//
// one texel per cycle sustained while the pixel side is ready; a result is registered in the
// lookup, add and clamp register stages in turn after its texel is taken.
// reset clears every stage valid bit and the config registers to zero (format argb4444).
// each stage holds while it and every later stage are full and the pixel side is not ready;
// empty stages close up, so texel.ready drops only when all three stages are full.
module texel_format_decoder_core import tfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	tfd_texel_if.sink    texel,
	tfd_pixel_if.source  pixel,
	tfd_cfg_if.sink      cfg
);

	cfg_t  cfg_regs;
	logic  vld_1, rdy_1, vld_2, rdy_2;
	look_t look_1;
	sum_t  sum_2;
	pix_t  pix_3;
	fmt_t  fmt_3;

	assign cfg.ready = 1'b1;

	tfd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	tfd_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_regs),
		.in_vld   (texel.valid),
		.in_texel (texel.texel_word),
		.in_rdy   (texel.ready),
		.out_vld  (vld_1),
		.out_data (look_1),
		.out_rdy  (rdy_1)
	);

	tfd_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_1),
		.in_data  (look_1),
		.in_rdy   (rdy_1),
		.out_vld  (vld_2),
		.out_data (sum_2),
		.out_rdy  (rdy_2)
	);

	tfd_clamp u_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_2),
		.in_data  (sum_2),
		.in_rdy   (rdy_2),
		.out_vld  (pixel.valid),
		.out_data (pix_3),
		.out_fmt  (fmt_3),
		.out_rdy  (pixel.ready)
	);

	assign pixel.red        = pix_3.red;
	assign pixel.green      = pix_3.green;
	assign pixel.blue       = pix_3.blue;
	assign pixel.alpha      = pix_3.alpha;
	assign pixel.format_bad = pix_3.format_bad;

	// backpressure only comes from the pixel side with the whole pipe full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!texel.ready |-> (vld_1 && vld_2 && pixel.valid && !pixel.ready))
		else $error("texel side stalled with a free stage");

	// a taken texel always lands in stage one
	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		texel.valid && texel.ready |=> vld_1)
		else $error("accepted texel lost at stage one");

	// unsupported format gives an all-zero word
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.format_bad |->
		(pixel.red == '0 && pixel.green == '0 && pixel.blue == '0 && pixel.alpha == '0))
		else $error("format_bad word carries colour");

	// flag and format agree, and ncc words are opaque
	a_bad_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid |-> (pixel.format_bad == (fmt_3 == FMT_BAD)))
		else $error("format_bad does not follow format");

	a_ncc_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && fmt_3 == FMT_YIQ422 |-> pixel.alpha == '1)
		else $error("ncc word not opaque");

endmodule

FILE: rtl/tfd_cfg_regs.sv
// format and ncc table registers
module tfd_cfg_regs import tfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [CfgDatW-1:0] wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TEXEL_FORMAT: cfg_q.fmt     <= fmt_t'(wr_data[1:0]);
				REG_LUMA_LOW:     cfg_q.luma_lo <= wr_data[LumaRegW-1:0];
				REG_LUMA_HIGH:    cfg_q.luma_hi <= wr_data[LumaRegW-1:0];
				REG_I_LOW:        cfg_q.i_lo    <= wr_data[ChromaRegW-1:0];
				REG_I_HIGH:       cfg_q.i_hi    <= wr_data[ChromaRegW-1:0];
				REG_Q_LOW:        cfg_q.q_lo    <= wr_data[ChromaRegW-1:0];
				REG_Q_HIGH:       cfg_q.q_hi    <= wr_data[ChromaRegW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/tfd_lookup.sv
// stage 1: direct argb widening and ncc table lookups
module tfd_lookup import tfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_vld,
	input  logic [TexelW-1:0] in_texel,
	output logic              in_rdy,
	output logic              out_vld,
	output look_t             out_data,
	input  logic              out_rdy
);

	logic  vld_s1;
	look_t data_s1;
	look_t nxt;

	always_comb begin
		nxt      = '0;
		nxt.fmt  = cfg.fmt;
		nxt.luma = luma_sel(cfg.luma_lo, cfg.luma_hi, in_texel[7:4]);
		nxt.iv   = chroma_sel(cfg.i_lo, cfg.i_hi, in_texel[3:2]);
		nxt.qv   = chroma_sel(cfg.q_lo, cfg.q_hi, in_texel[1:0]);
		case (cfg.fmt)
			FMT_ARGB4444: begin
				nxt.dr = {in_texel[11:8], in_texel[11:8]};
				nxt.dg = {in_texel[7:4], in_texel[7:4]};
				nxt.db = {in_texel[3:0], in_texel[3:0]};
				nxt.da = {in_texel[15:12], in_texel[15:12]};
			end
			FMT_ARGB1555: begin
				nxt.dr = {in_texel[14:10], 3'b000};
				nxt.dg = {in_texel[9:5], 3'b000};
				nxt.db = {in_texel[4:0], 3'b000};
				nxt.da = {ChanW{in_texel[15]}};
			end
			default: ;
		endcase
	end

	assign in_rdy = !vld_s1 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			data_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = data_s1;

endmodule

FILE: rtl/tfd_sum.sv
// stage 2: luma plus i plus q for each colour channel
module tfd_sum import tfd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_vld,
	input  look_t in_data,
	output logic  in_rdy,
	output logic  out_vld,
	output sum_t  out_data,
	input  logic  out_rdy
);

	logic                   vld_s2;
	sum_t                   data_s2;
	sum_t                   nxt;
	logic signed [SumW-1:0] luma_ext;

	function automatic logic signed [SumW-1:0] sext(input logic signed [ChromaW-1:0] v);
		return {{(SumW-ChromaW){v[ChromaW-1]}}, v};
	endfunction

	always_comb begin
		luma_ext = {{(SumW-ChanW){1'b0}}, in_data.luma};
		nxt.fmt  = in_data.fmt;
		nxt.dr   = in_data.dr;
		nxt.dg   = in_data.dg;
		nxt.db   = in_data.db;
		nxt.da   = in_data.da;
		nxt.sr   = luma_ext + sext(in_data.iv.r) + sext(in_data.qv.r);
		nxt.sg   = luma_ext + sext(in_data.iv.g) + sext(in_data.qv.g);
		nxt.sb   = luma_ext + sext(in_data.iv.b) + sext(in_data.qv.b);
	end

	assign in_rdy = !vld_s2 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_rdy) begin
			vld_s2 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			data_s2 <= nxt;
		end
	end

	assign out_vld  = vld_s2;
	assign out_data = data_s2;

endmodule

FILE: rtl/tfd_clamp.sv
// stage 3: clamp, format select and output register
module tfd_clamp import tfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  sum_t in_data,
	output logic in_rdy,
	output logic out_vld,
	output pix_t out_data,
	output fmt_t out_fmt,
	input  logic out_rdy
);

	logic vld_s3;
	pix_t data_s3;
	fmt_t fmt_s3;
	pix_t nxt;

	always_comb begin
		nxt = '0;
		case (in_data.fmt)
			FMT_YIQ422: begin
				nxt.red   = clamp8(in_data.sr);
				nxt.green = clamp8(in_data.sg);
				nxt.blue  = clamp8(in_data.sb);
				nxt.alpha = '1;
			end
			FMT_BAD: begin
				nxt.format_bad = 1'b1;
			end
			default: begin
				nxt.red   = in_data.dr;
				nxt.green = in_data.dg;
				nxt.blue  = in_data.db;
				nxt.alpha = in_data.da;
			end
		endcase
	end

	assign in_rdy = !vld_s3 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_rdy) begin
			vld_s3 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			data_s3 <= nxt;
			fmt_s3  <= in_data.fmt;
		end
	end

	assign out_vld  = vld_s3;
	assign out_data = data_s3;
	assign out_fmt  = fmt_s3;

endmodule

FILE: tb/texel_decode_checker.sv
`timescale 1ns / 100ps
// checker for the texel decoder: shadows the registers, predicts each pixel and compares it
module texel_decode_checker import tfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  texel_valid,
	input  logic                  texel_ready,
	input  logic [TexelW-1:0]     texel_word,
	input  logic                  pixel_valid,
	input  logic                  pixel_ready,
	input  logic [ChanW-1:0]      red,
	input  logic [ChanW-1:0]      green,
	input  logic [ChanW-1:0]      blue,
	input  logic [ChanW-1:0]      alpha,
	input  logic                  format_bad,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CfgIdxW-1:0]    cfg_index,
	input  logic [CfgDatW-1:0]    cfg_data,
	output int                    mismatches,
	output int                    pending
);

	fmt_t                  fmt_r;
	logic [LumaRegW-1:0]   luma_lo_r, luma_hi_r;
	logic [ChromaRegW-1:0] i_lo_r, i_hi_r, q_lo_r, q_hi_r;

	pix_t due_pixels[$];
	int   bad_cnt;

	// 9-bit signed chroma value for one channel (0 r, 1 g, 2 b) of table entry e
	function automatic int chroma_val(input logic [ChromaRegW-1:0] lo,
		input logic [ChromaRegW-1:0] hi, input logic [1:0] e, input int ch);
		logic [ChromaRegW-1:0] w;
		logic [ChromaW-1:0]    raw;
		w = e[1] ? hi : lo;
		raw = ChromaW'(w >> (int'(e[0]) * TripleW + ch * ChromaW));
		return raw[ChromaW-1] ? int'(raw) - 512 : int'(raw);
	endfunction

	function automatic logic [ChanW-1:0] sat8(input int v);
		if (v < 0)
			return 8'h00;
		if (v > 255)
			return 8'hFF;
		return ChanW'(v);
	endfunction

	function automatic pix_t decode_texel(input logic [TexelW-1:0] t);
		pix_t                p;
		logic [LumaRegW-1:0] lw;
		int                  y;
		int                  sum [3];
		p = '0;
		case (fmt_r)
			FMT_ARGB4444: begin
				p.red   = 8'(t[11:8]) * 8'd17;
				p.green = 8'(t[7:4]) * 8'd17;
				p.blue  = 8'(t[3:0]) * 8'd17;
				p.alpha = 8'(t[15:12]) * 8'd17;
			end
			FMT_ARGB1555: begin
				p.red   = {t[14:10], 3'b000};
				p.green = {t[9:5], 3'b000};
				p.blue  = {t[4:0], 3'b000};
				p.alpha = t[15] ? 8'hFF : 8'h00;
			end
			FMT_YIQ422: begin
				// only the low byte counts: y in [7:4], i in [3:2], q in [1:0]
				lw = t[7] ? luma_hi_r : luma_lo_r;
				y = int'(ChanW'(lw >> (int'(t[6:4]) * 8)));
				for (int c = 0; c < 3; c++)
					sum[c] = y + chroma_val(i_lo_r, i_hi_r, t[3:2], c)
						+ chroma_val(q_lo_r, q_hi_r, t[1:0], c);
				p.red   = sat8(sum[0]);
				p.green = sat8(sum[1]);
				p.blue  = sat8(sum[2]);
				p.alpha = 8'hFF;
			end
			default: begin
				p.format_bad = 1'b1;
			end
		endcase
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pix_t want, got;
		if (!arst_n) begin
			fmt_r      <= FMT_ARGB4444;
			luma_lo_r  <= '0;
			luma_hi_r  <= '0;
			i_lo_r     <= '0;
			i_hi_r     <= '0;
			q_lo_r     <= '0;
			q_hi_r     <= '0;
			due_pixels.delete();
			bad_cnt = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			// predict with the settings in force before any write on this edge
			if (texel_valid && texel_ready)
				due_pixels.insert(due_pixels.size(), decode_texel(texel_word));
			if (pixel_valid && pixel_ready) begin
				got.red        = red;
				got.green      = green;
				got.blue       = blue;
				got.alpha      = alpha;
				got.format_bad = format_bad;
				if (due_pixels.size() == 0) begin
					if (bad_cnt < 10)
						$display("%0t: unexpected pixel word r=%02h g=%02h b=%02h a=%02h bad=%b",
							$realtime, got.red, got.green, got.blue, got.alpha, got.format_bad);
					bad_cnt++;
				end else begin
					want = due_pixels.pop_front();
					if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
						|| got.alpha !== want.alpha || got.format_bad !== want.format_bad) begin
						if (bad_cnt < 10)
							$display({"%0t: pixel word exp r=%02h g=%02h b=%02h a=%02h bad=%b,",
								" got r=%02h g=%02h b=%02h a=%02h bad=%b"},
								$realtime, want.red, want.green, want.blue, want.alpha,
								want.format_bad, got.red, got.green, got.blue, got.alpha,
								got.format_bad);
						bad_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEXEL_FORMAT: fmt_r     <= fmt_t'(cfg_data[1:0]);
					REG_LUMA_LOW:     luma_lo_r <= cfg_data;
					REG_LUMA_HIGH:    luma_hi_r <= cfg_data;
					REG_I_LOW:        i_lo_r    <= cfg_data[ChromaRegW-1:0];
					REG_I_HIGH:       i_hi_r    <= cfg_data[ChromaRegW-1:0];
					REG_Q_LOW:        q_lo_r    <= cfg_data[ChromaRegW-1:0];
					REG_Q_HIGH:       q_hi_r    <= cfg_data[ChromaRegW-1:0];
					default: ;
				endcase
			end
			pending    <= due_pixels.size();
			mismatches <= bad_cnt;
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// top of the texel decoder testbench: clock, reset, texel and register stimulus, verdict
module testbench;
	import tfd_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7; // no register behind this index
	localparam int PipeDepth = 3;
	localparam int LongHold  = 60;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches, pending;
	bit   src_gaps, sink_gaps, sink_hold;

	tfd_texel_if texel();
	tfd_pixel_if pixel();
	tfd_cfg_if   cfg();

	texel_format_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.texel  (texel),
		.pixel  (pixel),
		.cfg    (cfg)
	);

	texel_decode_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.texel_valid (texel.valid),
		.texel_ready (texel.ready),
		.texel_word  (texel.texel_word),
		.pixel_valid (pixel.valid),
		.pixel_ready (pixel.ready),
		.red         (pixel.red),
		.green       (pixel.green),
		.blue        (pixel.blue),
		.alpha       (pixel.alpha),
		.format_bad  (pixel.format_bad),
		.cfg_valid   (cfg.valid),
		.cfg_ready   (cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// valid stays high when the next word follows with no gap
	task automatic send_texel(input logic [TexelW-1:0] word);
		int gap;
		gap = src_gaps ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			texel.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		texel.valid      <= 1'b1;
		texel.texel_word <= word;
		do @(posedge clk); while (!texel.ready);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic program_regs(input logic [CfgDatW-1:0] fmt_word,
		input logic [CfgDatW-1:0] luma_lo, input logic [CfgDatW-1:0] luma_hi,
		input logic [CfgDatW-1:0] i_lo, input logic [CfgDatW-1:0] i_hi,
		input logic [CfgDatW-1:0] q_lo, input logic [CfgDatW-1:0] q_hi);
		write_reg(REG_TEXEL_FORMAT, fmt_word);
		write_reg(REG_LUMA_LOW, luma_lo);
		write_reg(REG_LUMA_HIGH, luma_hi);
		write_reg(REG_I_LOW, i_lo);
		write_reg(REG_I_HIGH, i_hi);
		write_reg(REG_Q_LOW, q_lo);
		write_reg(REG_Q_HIGH, q_hi);
		// an out-of-range index must leave everything above untouched
		write_reg(REG_SPARE, {$urandom, $urandom});
		cfg.valid <= 1'b0;
	endtask

	// stop offering texels and wait until every pixel has come back
	task automatic drain();
		texel.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (PipeDepth + 2) @(posedge clk);
	endtask

	function automatic logic [CfgDatW-1:0] table_word();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// pixel side: random stalls, plus one long hold-off when asked
	initial begin
		int gap;
		pixel.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (sink_hold) begin
				pixel.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				sink_hold = 1'b0;
			end
			gap = sink_gaps ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				pixel.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pixel.ready <= 1'b1;
			do @(posedge clk); while (!pixel.valid);
		end
	end

	initial begin
		logic [CfgDatW-1:0] fmt_word;
		fmt_t               fmt;
		arst_n           <= 1'b0;
		texel.valid      <= 1'b0;
		texel.texel_word <= '0;
		cfg.valid        <= 1'b0;
		cfg.index        <= '0;
		cfg.data         <= '0;
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		sink_hold = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset leaves argb4444 selected
		send_texel(16'h0000);
		send_texel(16'hFFFF);
		send_texel(16'h1234);
		send_texel(16'hEDCB);
		drain();

		program_regs({62'h3FFF_0000_FFFF_0000, FMT_ARGB1555}, '0, '0, '0, '0, '0, '0);
		send_texel(16'h0000);
		send_texel(16'hFFFF);
		send_texel(16'h8000);
		send_texel(16'h7FFF);
		send_texel(16'h4210);
		drain();

		// tables built so that luma 0 with the most negative chroma and luma 255 with
		// the most positive chroma saturate low and high
		program_regs({62'h15A5_A5A5_A5A5_A5A5, FMT_YIQ422},
			64'h7060_5040_3020_1000, 64'hFFE0_D0C0_B0A0_9080,
			{10'h3FF, 9'h001, 9'h1FF, 9'h010, 9'h100, 9'h100, 9'h100},
			{10'h2AA, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h100, 9'h000},
			{10'h155, 9'h020, 9'h1E0, 9'h000, 9'h100, 9'h100, 9'h100},
			{10'h3FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1C0, 9'h040, 9'h080});
		send_texel(16'h0000);
		send_texel(16'h12FF);
		send_texel(16'hFF00);
		send_texel(16'h0085);
		send_texel(16'h003A);
		send_texel(16'h00C6);
		drain();

		program_regs('1, '1, '1, '1, '1, '1, '1);
		send_texel(16'h0000);
		send_texel(16'hFFFF);
		send_texel(16'h5A5A);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			fmt = (ph < 4) ? fmt_t'(ph) : fmt_t'($urandom_range(0, 3));
			fmt_word = {$urandom, $urandom};
			fmt_word[1:0] = fmt;
			program_regs(fmt_word, table_word(), table_word(), table_word(), table_word(),
				table_word(), table_word());
			src_gaps  = $urandom_range(0, 3) != 0;
			sink_gaps = $urandom_range(0, 3) != 0;
			if (ph == 2) begin
				// back-to-back texels against a stalled pixel side fill the pipeline
				sink_hold = 1'b1;
				src_gaps  = 1'b0;
				repeat (24) send_texel(16'($urandom));
				src_gaps = 1'b1;
			end
			repeat (100) send_texel(16'($urandom));
			drain();
		end

		if (mismatches == 0 && pending == 0)
			$display("texel_format_decoder_core: match");
		else
			$display("texel_format_decoder_core: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("texel_format_decoder_core: mismatch");
		$finish;
	end

endmodule

FILE: texel_format_decoder_core.f
rtl/tfd_pkg.sv
rtl/tfd_if.sv
rtl/tfd_cfg_regs.sv
rtl/tfd_lookup.sv
rtl/tfd_sum.sv
rtl/tfd_clamp.sv
rtl/texel_format_decoder_core.sv
tb/texel_decode_checker.sv
tb/testbench.sv
